>>> rtl/three_wire_rtc_serial_master_unit_defines.svh
// ---------------------------------------------------------------------------
// three-wire rtc serial master - assertion macros
// concurrent checks clocked on clk, disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_UNIT_DEFINES_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TWRTC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("twrtc assertion failed");
`define TWRTC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("twrtc assertion failed");
`else
`define TWRTC_ASSERT(lbl, prop)
`define TWRTC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/twrtc_pkg.sv
// ---------------------------------------------------------------------------
// twrtc_pkg
// types, codes and bcd helpers shared by the three-wire rtc serial master
// ---------------------------------------------------------------------------
package twrtc_pkg;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;

	localparam logic [2:0] LAST_BIT = 3'd7;

	typedef enum logic [1:0] {
		PH_CMD  = 2'd0,
		PH_DATA = 2'd1,
		PH_RECV = 2'd2
	} phase_t;

	typedef struct packed {
		logic       active;
		logic       is_read;
		phase_t     phase;
		logic [2:0] bit_index;
		logic       clock_high;
		logic [7:0] tx_shift;
		logic [7:0] write_byte;
		logic [7:0] rx_shift;
	} core_state_t;

	typedef struct packed {
		logic       enable_pin;
		logic       sclk_pin;
		logic       io_out;
		logic       io_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_value;
	} result_t;

	// divide by ten through the reciprocal 205/2048, exact for 7-bit values
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  tens_w;
		logic [6:0]  rem;
		prod   = 15'(v) * 15'd205;
		tens   = prod[14:11];
		tens_w = {3'b000, tens};
		rem    = v - (tens_w << 3) - (tens_w << 1);
		return {tens, 4'b0000} + {1'b0, rem};
	endfunction

	function automatic logic [7:0] from_bcd(input logic [7:0] b);
		logic [7:0] hi;
		hi = {4'b0000, b[7:4]};
		return (hi << 3) + (hi << 1) + {4'b0000, b[3:0]};
	endfunction

endpackage

>>> rtl/twrtc_core.sv
// ---------------------------------------------------------------------------
// twrtc_core
// transaction state and one half-period step of the serial link per request
// ---------------------------------------------------------------------------
`include "three_wire_rtc_serial_master_unit_defines.svh"

module twrtc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [1:0]          req_type,
	input  logic [7:0]          reg_addr,
	input  logic [6:0]          value_dec,
	input  logic                io_in,
	output twrtc_pkg::result_t  res
);

	twrtc_pkg::core_state_t cur_q;
	twrtc_pkg::core_state_t nxt;
	logic                   done;
	logic [7:0]             rx_upd;

	assign rx_upd = cur_q.rx_shift | (8'(io_in) << cur_q.bit_index);

	always_comb begin
		nxt  = cur_q;
		done = 1'b0;
		if (!cur_q.active) begin
			if (req_type == twrtc_pkg::REQ_READ || req_type == twrtc_pkg::REQ_WRITE) begin
				nxt.active     = 1'b1;
				nxt.is_read    = (req_type == twrtc_pkg::REQ_READ);
				nxt.phase      = twrtc_pkg::PH_CMD;
				nxt.bit_index  = 3'd0;
				nxt.clock_high = 1'b0;
				nxt.rx_shift   = 8'd0;
				if (req_type == twrtc_pkg::REQ_READ) begin
					nxt.tx_shift = reg_addr + 8'd1;
				end else begin
					nxt.tx_shift   = reg_addr;
					nxt.write_byte = twrtc_pkg::to_bcd(value_dec);
				end
			end
		end else begin
			unique case (cur_q.phase)
				twrtc_pkg::PH_CMD, twrtc_pkg::PH_DATA: begin
					if (!cur_q.clock_high) begin
						nxt.clock_high = 1'b1;
					end else begin
						nxt.clock_high = 1'b0;
						if (cur_q.bit_index != twrtc_pkg::LAST_BIT) begin
							nxt.bit_index = cur_q.bit_index + 3'd1;
						end else begin
							nxt.bit_index = 3'd0;
							if (cur_q.phase == twrtc_pkg::PH_CMD) begin
								if (cur_q.is_read) begin
									nxt.phase = twrtc_pkg::PH_RECV;
								end else begin
									nxt.phase    = twrtc_pkg::PH_DATA;
									nxt.tx_shift = cur_q.write_byte;
								end
							end else begin
								nxt.active = 1'b0;
								nxt.phase  = twrtc_pkg::PH_CMD;
								done       = 1'b1;
							end
						end
					end
				end
				twrtc_pkg::PH_RECV: begin
					if (!cur_q.clock_high) begin
						nxt.rx_shift = rx_upd;
						if (cur_q.bit_index == twrtc_pkg::LAST_BIT) begin
							nxt.active    = 1'b0;
							nxt.phase     = twrtc_pkg::PH_CMD;
							nxt.bit_index = 3'd0;
							done          = 1'b1;
						end else begin
							nxt.clock_high = 1'b1;
						end
					end else begin
						nxt.clock_high = 1'b0;
						nxt.bit_index  = cur_q.bit_index + 3'd1;
					end
				end
				default: begin
					nxt.active     = 1'b0;
					nxt.phase      = twrtc_pkg::PH_CMD;
					nxt.bit_index  = 3'd0;
					nxt.clock_high = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		res.enable_pin = nxt.active;
		res.sclk_pin   = nxt.active & nxt.clock_high;
		res.io_drive   = nxt.active &
			(nxt.phase == twrtc_pkg::PH_CMD || nxt.phase == twrtc_pkg::PH_DATA);
		res.io_out     = res.io_drive & nxt.tx_shift[nxt.bit_index];
		res.busy_res   = nxt.active;
		res.done_res   = done;
		res.read_value = (done && cur_q.is_read) ? twrtc_pkg::from_bcd(nxt.rx_shift) : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (step) begin
			cur_q <= nxt;
		end
	end

	`TWRTC_ASSERT(a_done_ends, !(done && nxt.active))
	`TWRTC_ASSERT(a_recv_released,
		!(cur_q.active && cur_q.phase == twrtc_pkg::PH_RECV && res.io_drive && !done))
	`TWRTC_ASSERT_NEXT(a_start_low_clock, step && !cur_q.active && nxt.active,
		cur_q.active && !cur_q.clock_high && cur_q.bit_index == 3'd0)

endmodule

>>> rtl/twrtc_obuf.sv
// ---------------------------------------------------------------------------
// twrtc_obuf
// result register with one skid entry so a stalled result does not stop input
// ---------------------------------------------------------------------------
`include "three_wire_rtc_serial_master_unit_defines.svh"

module twrtc_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_accept,
	input  twrtc_pkg::result_t  in_res,
	output logic                full,
	output logic                out_valid,
	input  logic                out_stall,
	output twrtc_pkg::result_t  out_res
);

	logic               main_valid_q;
	logic               skid_valid_q;
	twrtc_pkg::result_t main_q;
	twrtc_pkg::result_t skid_q;
	logic               out_fire;

	assign out_fire  = main_valid_q & ~out_stall;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			priority if (skid_valid_q && out_fire) begin
				skid_valid_q <= 1'b0;
			end else if (in_accept && main_valid_q && !out_fire) begin
				skid_valid_q <= 1'b1;
			end else if (in_accept) begin
				main_valid_q <= 1'b1;
			end else if (out_fire) begin
				main_valid_q <= 1'b0;
			end else begin
				main_valid_q <= main_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (skid_valid_q && out_fire) begin
			main_q <= skid_q;
		end else if (in_accept && main_valid_q && !out_fire) begin
			skid_q <= in_res;
		end else if (in_accept) begin
			main_q <= in_res;
		end else begin
			main_q <= main_q;
		end
	end

	`TWRTC_ASSERT(a_skid_behind_main, !skid_valid_q || main_valid_q)
	`TWRTC_ASSERT_NEXT(a_skid_drains, skid_valid_q && !out_stall, main_valid_q && !skid_valid_q)
	`TWRTC_ASSERT_NEXT(a_skid_fills, in_accept && main_valid_q && out_stall, skid_valid_q)

endmodule

>>> rtl/three_wire_rtc_serial_master_unit.sv
// ---------------------------------------------------------------------------
// three_wire_rtc_serial_master_unit
// bit-level master for a three-wire rtc link, one half clock period a request
// ---------------------------------------------------------------------------
// each input request is one half period of the serial clock: req_type starts
// a read or a write, or just ticks the transaction along; io_in is the data
// line level sampled for that half period.
// every accepted request gives exactly one result with the enable, clock and
// data line levels for the following half period, plus busy, done and the
// received value converted from bcd.
// the state update runs in the cycle a request is taken and the result is
// registered, and a request can be taken every cycle while in_stall is low
// (one per cycle, set by the single state update).
// a skid entry behind the result register lets one more request in while a
// result is stalled; in_stall rises only when both entries hold results.
// a write takes 33 requests from start to done, a read 32.
// reset clears the transaction state and empties the result register.
// ---------------------------------------------------------------------------
module three_wire_rtc_serial_master_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [7:0] reg_addr,
	input  logic [6:0] value_dec,
	input  logic       io_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       enable_pin,
	output logic       sclk_pin,
	output logic       io_out,
	output logic       io_drive,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_value
);

	logic               step;
	logic               full;
	twrtc_pkg::result_t res;
	twrtc_pkg::result_t out_res;

	assign in_stall = full;
	assign step     = in_valid & ~full;

	twrtc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.req_type  (req_type),
		.reg_addr  (reg_addr),
		.value_dec (value_dec),
		.io_in     (io_in),
		.res       (res)
	);

	twrtc_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (step),
		.in_res    (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign enable_pin = out_res.enable_pin;
	assign sclk_pin   = out_res.sclk_pin;
	assign io_out     = out_res.io_out;
	assign io_drive   = out_res.io_drive;
	assign busy_res   = out_res.busy_res;
	assign done_res   = out_res.done_res;
	assign read_value = out_res.read_value;

endmodule
